/* rtl/wtx_pkg.sv */
// Shared types, opcodes and error codes for the width-tagged integer execution unit.
// No dependencies.
package wtx_pkg;

  localparam int NUM_REGS  = 64;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = 6;
  localparam int WID_W     = 6;

  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_LIMM = 8'h02;
  localparam logic [7:0] OP_CND  = 8'h04;
  localparam logic [7:0] OP_OR   = 8'h10;
  localparam logic [7:0] OP_XOR  = 8'h11;
  localparam logic [7:0] OP_AND  = 8'h12;
  localparam logic [7:0] OP_SBX  = 8'h13;
  localparam logic [7:0] OP_ADD  = 8'h14;
  localparam logic [7:0] OP_SUB  = 8'h15;
  localparam logic [7:0] OP_MUL  = 8'h16;
  localparam logic [7:0] OP_SHL  = 8'h18;
  localparam logic [7:0] OP_SAR  = 8'h19;
  localparam logic [7:0] OP_DIV  = 8'h1a;
  localparam logic [7:0] OP_MOD  = 8'h1b;
  localparam logic [7:0] OP_CEQ  = 8'h20;
  localparam logic [7:0] OP_CNE  = 8'h21;
  localparam logic [7:0] OP_CLT  = 8'h22;
  localparam logic [7:0] OP_CGE  = 8'h23;
  localparam logic [7:0] OP_CLE  = 8'h24;
  localparam logic [7:0] OP_CGT  = 8'h25;
  localparam logic [7:0] OP_CTZ  = 8'h26;
  localparam logic [7:0] OP_CTNZ = 8'h27;

  localparam logic [IDX_W-1:0] SHIFT_REG = 6'h3f;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_BITS  = 3'd1;
  localparam logic [2:0] ERR_SHIFT = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_RANGE = 3'd4;

  // Controller to datapath.
  typedef struct packed {
    logic clear;      // write zero at clr_idx
    logic latch_in;   // capture request fields
    logic rd_ops;     // read operands
    logic exec;       // evaluate and start divide
    logic div_step;   // one restoring divide step
    logic finish;     // commit and form result
  } wtx_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_div;
    logic div_last;
  } wtx_sts_t;

endpackage

/* rtl/wtx_datapath.sv */
// Register file, ALU, bit-serial divider and result register of the execution unit.
// Depends on wtx_pkg.
module wtx_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wtx_pkg::wtx_cmd_t     cmd,
  output wtx_pkg::wtx_sts_t     sts,
  input  logic [7:0]            in_opcode,
  input  logic [5:0]            in_src_a,
  input  logic [5:0]            in_src_b,
  input  logic [5:0]            in_dest,
  input  logic [5:0]            in_width,
  input  logic [5:0]            in_cmp_width,
  input  logic signed [31:0]    in_immediate,
  output logic [2:0]            res_error_code,
  output logic                  res_handled,
  output logic [2:0]            res_words_used,
  output logic                  res_skip_next
);

  logic [31:0] val_mem [wtx_pkg::NUM_REGS];
  logic [5:0]  wid_mem [wtx_pkg::NUM_REGS];

  logic [5:0]  clr_idx_r;
  logic [7:0]  op_r;
  logic [5:0]  ra_r, rb_r, rd_r, w_r, cw_r;
  logic [31:0] imm_r;
  logic [31:0] a_r, b_r, pos_r;
  logic [31:0] sh63_r;
  logic [5:0]  wa_r, wb_r;
  logic [31:0] res_r;
  logic [2:0]  err_r, words_r;
  logic        hand_r, skip_r, wr_r, chk_r;
  logic [31:0] quo_r, rem_r, dvs_r;
  logic [4:0]  dcnt_r;
  logic        neg_r;
  logic [31:0] dmag, fres;

  // Port A reads a and its width, port B b and its width. The sign position
  // lives in a copy of register 63 kept beside the memory.
  always_ff @(posedge clk) begin
    if (cmd.rd_ops) begin
      a_r   <= val_mem[ra_r];
      wa_r  <= wid_mem[ra_r];
      b_r   <= val_mem[rb_r];
      wb_r  <= wid_mem[rb_r];
      pos_r <= sh63_r;
    end
  end

  // Memory write: clearing pass or final commit.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      val_mem[clr_idx_r] <= '0;
      wid_mem[clr_idx_r] <= '0;
    end else if (cmd.finish && wr_r) begin
      val_mem[rd_r] <= fres;
      wid_mem[rd_r] <= w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sh63_r <= '0;
    else if (cmd.finish && wr_r && (rd_r == wtx_pkg::SHIFT_REG)) sh63_r <= fres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_idx_r <= '0;
    else if (cmd.clear) clr_idx_r <= clr_idx_r + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= in_opcode; ra_r <= in_src_a; rb_r <= in_src_b; rd_r <= in_dest;
      w_r <= in_width; cw_r <= in_cmp_width; imm_r <= in_immediate;
    end
  end

  logic is_bin, is_cmp, is_shf, is_div;
  assign is_bin = (op_r >= wtx_pkg::OP_OR) && (op_r <= wtx_pkg::OP_MUL)
                  && (op_r != wtx_pkg::OP_SBX);
  assign is_cmp = (op_r >= wtx_pkg::OP_CEQ) && (op_r <= wtx_pkg::OP_CTNZ);
  assign is_shf = (op_r == wtx_pkg::OP_SHL) || (op_r == wtx_pkg::OP_SAR);
  assign is_div = (op_r == wtx_pkg::OP_DIV) || (op_r == wtx_pkg::OP_MOD);

  logic [31:0] ua, ub, hi, alu;
  logic        slt_ab, slt_ba, t, sbad, pbad, wbad2, wbad1;
  logic [2:0]  e;
  logic [2:0]  wd;
  logic        hd, wr;
  logic [31:0] shl_v, sar_v, sbx_v, prod;

  assign ua = a_r[31] ? (32'd0 - a_r) : a_r;
  assign ub = b_r[31] ? (32'd0 - b_r) : b_r;
  assign slt_ab = $signed(a_r) < $signed(b_r);
  assign slt_ba = $signed(b_r) < $signed(a_r);
  assign wbad1 = w_r > wa_r;
  assign wbad2 = wbad1 || (w_r > wb_r);
  assign sbad = b_r[31] || (b_r >= {26'd0, w_r});
  assign pbad = pos_r[31] || (pos_r >= {26'd0, w_r});
  // Counts are below width (at most 63) here, so five bits plus a range test suffice.
  assign shl_v = (b_r[31:5] != '0) ? 32'd0 : (a_r << b_r[4:0]);
  assign sar_v = (b_r[31:5] != '0) ? {32{a_r[31]}} : 32'($signed(a_r) >>> b_r[4:0]);
  assign hi    = (pos_r[31:5] != '0) ? 32'd0 : (32'hffffffff << pos_r[4:0]);
  assign sbx_v = ((pos_r[31:5] == '0) && a_r[pos_r[4:0]]) ? (a_r | hi) : (a_r & ~hi);
  assign prod  = a_r * b_r;

  always_comb begin
    case (op_r)
      wtx_pkg::OP_CEQ: t = (a_r == b_r);
      wtx_pkg::OP_CNE: t = (a_r != b_r);
      wtx_pkg::OP_CLT: t = slt_ab;
      wtx_pkg::OP_CGE: t = !slt_ab;
      wtx_pkg::OP_CLE: t = !slt_ba;
      wtx_pkg::OP_CGT: t = slt_ba;
      wtx_pkg::OP_CTZ: t = ((a_r & b_r) == '0);
      default:         t = ((a_r & b_r) != '0);
    endcase
    case (op_r)
      wtx_pkg::OP_OR:  alu = a_r | b_r;
      wtx_pkg::OP_XOR: alu = a_r ^ b_r;
      wtx_pkg::OP_AND: alu = a_r & b_r;
      wtx_pkg::OP_ADD: alu = a_r + b_r;
      wtx_pkg::OP_SUB: alu = a_r - b_r;
      wtx_pkg::OP_SBX: alu = sbx_v;
      wtx_pkg::OP_SHL: alu = shl_v;
      wtx_pkg::OP_SAR: alu = sar_v;
      wtx_pkg::OP_LIMM: alu = imm_r;
      default:         alu = prod;
    endcase
  end

  always_comb begin
    e = wtx_pkg::ERR_OK; wd = 3'd0; hd = 1'b1; wr = 1'b0;
    if (op_r == wtx_pkg::OP_NOP) begin
      wd = 3'd1;
    end else if (op_r == wtx_pkg::OP_LIMM) begin
      wd = 3'd4; wr = 1'b1;
    end else if (op_r == wtx_pkg::OP_CND) begin
      wd = 3'd2;
    end else if (is_bin) begin
      if (wbad2) e = wtx_pkg::ERR_BITS;
      else begin wd = 3'd5; wr = 1'b1; end
    end else if (op_r == wtx_pkg::OP_SBX) begin
      if (wbad1) e = wtx_pkg::ERR_BITS;
      else if (pbad) e = wtx_pkg::ERR_SHIFT;
      else begin wd = 3'd5; wr = 1'b1; end
    end else if (is_shf) begin
      if (wbad1) e = wtx_pkg::ERR_BITS;
      else if (sbad) e = wtx_pkg::ERR_SHIFT;
      else begin wd = 3'd5; wr = 1'b1; end
    end else if (is_div) begin
      if (wbad2) e = wtx_pkg::ERR_BITS;
      else if (b_r == '0) e = wtx_pkg::ERR_DIV0;
      else begin wd = 3'd5; wr = 1'b1; end
    end else if (is_cmp) begin
      if (cw_r > wa_r || cw_r > wb_r) e = wtx_pkg::ERR_BITS;
      else begin wd = 3'd6; wr = 1'b1; end
    end else begin
      hd = 1'b0;
    end
  end

  // One restoring step a cycle on the magnitudes.
  logic [32:0] trial;
  logic        clr_last, div_last;
  assign trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};
  assign clr_last = (clr_idx_r == 6'h3f);
  assign div_last = (dcnt_r == 5'd31);
  assign sts = '{clr_last: clr_last, is_div: is_div && wr, div_last: div_last};

  always_ff @(posedge clk) begin
    if (!rst_n) dcnt_r <= '0;
    else if (cmd.exec) dcnt_r <= '0;
    else if (cmd.div_step) dcnt_r <= dcnt_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      quo_r <= ua; rem_r <= '0; dvs_r <= ub;
      neg_r <= (op_r == wtx_pkg::OP_DIV) ? (a_r[31] ^ b_r[31]) : a_r[31];
      err_r <= e; words_r <= wd; hand_r <= hd; wr_r <= wr;
      skip_r <= (op_r == wtx_pkg::OP_CND) && !a_r[0];
      chk_r <= !is_cmp;
      res_r <= is_cmp ? {32{t}} : alu;
    end else if (cmd.div_step) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0]; quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], quo_r[31]}; quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign dmag = (op_r == wtx_pkg::OP_DIV) ? quo_r : rem_r;
  assign fres = (is_div && wr_r) ? (neg_r ? 32'd0 - dmag : dmag) : res_r;

  logic oor;
  logic [31:0] lim;
  assign lim = 32'd1 << 5'(w_r - 6'd1);
  assign oor = chk_r && (w_r != 6'd0) && (w_r < 6'd32) && ((fres + lim) >= (lim << 1));

  // The committed value and the range check both use fres, the signed divide result
  // for DIV and MOD and the registered ALU or compare result otherwise.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_error_code <= (err_r != wtx_pkg::ERR_OK) ? err_r
                        : ((wr_r && oor) ? wtx_pkg::ERR_RANGE : wtx_pkg::ERR_OK);
      res_handled    <= hand_r;
      res_words_used <= (err_r != wtx_pkg::ERR_OK) ? 3'd0
                        : ((wr_r && oor) ? 3'd0 : words_r);
      res_skip_next  <= skip_r;
    end
  end

endmodule

/* rtl/wtx_ctrl.sv */
// Controller state machine of the execution unit: clearing pass, operand read,
// divide iteration and result hand-off. Depends on wtx_pkg.
module wtx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output wtx_pkg::wtx_cmd_t cmd,
  input  wtx_pkg::wtx_sts_t sts
);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_EXE  = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (out_valid && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin cmd.latch_in = 1'b1; state_nxt = S_RD; end
      end
      S_RD: begin cmd.rd_ops = 1'b1; state_nxt = S_EXE; end
      S_EXE: begin
        cmd.exec = 1'b1;
        state_nxt = S_FIN;
        if (sts.is_div) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_nxt) begin
          cmd.finish = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall) else $error("accept during clear");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("finish without result");
  a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> sts.is_div) else $error("divide step on non-divide");

endmodule

/* rtl/width_tagged_integer_exec_unit.sv */
// Width-tagged integer execution unit, top level. Instantiates wtx_ctrl and wtx_datapath;
// depends on wtx_pkg.
//
// Each request runs one instruction against the 64-entry register file. After reset a
// clearing pass zeroes the file, during which in_stall is high. A request passes through
// register read, execute and commit before its result appears. DIV and MOD that reach the
// divider run 32 restoring steps in the one-bit-per-cycle divider between execute and
// commit. One request is in flight at a time: in_stall drops the cycle after commit, so a
// new request cannot be accepted until the last one has committed. A result waiting on
// out_stall does not hold off acceptance of the next request, but the commit of that
// request waits for it to drain.
module width_tagged_integer_exec_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_opcode,
  input  logic [5:0]         in_src_a,
  input  logic [5:0]         in_src_b,
  input  logic [5:0]         in_dest,
  input  logic [5:0]         in_width,
  input  logic [5:0]         in_cmp_width,
  input  logic signed [31:0] in_immediate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_error_code,
  output logic               out_handled,
  output logic [2:0]         out_words_used,
  output logic               out_skip_next
);

  wtx_pkg::wtx_cmd_t cmd;
  wtx_pkg::wtx_sts_t sts;

  wtx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  wtx_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_opcode), .in_src_a(in_src_a), .in_src_b(in_src_b),
    .in_dest(in_dest), .in_width(in_width), .in_cmp_width(in_cmp_width),
    .in_immediate(in_immediate),
    .res_error_code(out_error_code), .res_handled(out_handled),
    .res_words_used(out_words_used), .res_skip_next(out_skip_next)
  );

endmodule

/* bench/width_tagged_integer_exec_unit_tb.sv */
// Self-checking bench for width_tagged_integer_exec_unit: predicts each result from its
// own register file model and checks it in order. Depends on wtx_pkg and the RTL top.
module width_tagged_integer_exec_unit_tb;

  typedef struct packed {
    logic [2:0] err;
    logic       handled;
    logic [2:0] words;
    logic       skip;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0] regv [wtx_pkg::NUM_REGS];
    logic [5:0]  regw [wtx_pkg::NUM_REGS];
    exec_result_t pending[$];
    int errors;
    int checked;

    function void reset_file();
      for (int k = 0; k < wtx_pkg::NUM_REGS; k++) begin
        regv[k] = '0;
        regw[k] = '0;
      end
      errors = 0;
      checked = 0;
    endfunction

    function bit over_range(logic [31:0] v, logic [5:0] w);
      logic [31:0] lim;
      if (w == 0 || w >= 32) return 0;
      lim = 32'd1 << (w - 1);
      return (v + lim) >= (lim << 1);
    endfunction

    function logic [2:0] commit(logic [5:0] d, logic [31:0] v, logic [5:0] w);
      regv[d] = v;
      regw[d] = w;
      return over_range(v, w) ? wtx_pkg::ERR_RANGE : wtx_pkg::ERR_OK;
    endfunction

    function void note_request(logic [7:0] op, logic [5:0] ra, logic [5:0] rb,
                               logic [5:0] rd, logic [5:0] w, logic [5:0] cw,
                               logic [31:0] imm);
      exec_result_t r;
      logic [31:0] a, b, res, pos, ua, ub;
      logic signed [31:0] sa, sb;
      bit t;
      a = regv[ra];
      b = regv[rb];
      sa = a;
      sb = b;
      r = '0;
      r.handled = 1;
      case (op)
        wtx_pkg::OP_NOP: r.words = 1;
        wtx_pkg::OP_LIMM: begin
          r.err = commit(rd, imm, w);
          r.words = 4;
        end
        wtx_pkg::OP_CND: begin
          r.skip = ~a[0];
          r.words = 2;
        end
        wtx_pkg::OP_OR, wtx_pkg::OP_XOR, wtx_pkg::OP_AND, wtx_pkg::OP_ADD,
        wtx_pkg::OP_SUB, wtx_pkg::OP_MUL: begin
          if (w > regw[ra] || w > regw[rb]) r.err = wtx_pkg::ERR_BITS;
          else begin
            case (op)
              wtx_pkg::OP_OR:  res = a | b;
              wtx_pkg::OP_XOR: res = a ^ b;
              wtx_pkg::OP_AND: res = a & b;
              wtx_pkg::OP_ADD: res = a + b;
              wtx_pkg::OP_SUB: res = a - b;
              default:         res = a * b;
            endcase
            r.err = commit(rd, res, w);
            r.words = 5;
          end
        end
        wtx_pkg::OP_SBX: begin
          pos = regv[wtx_pkg::SHIFT_REG];
          if (w > regw[ra]) r.err = wtx_pkg::ERR_BITS;
          else if (pos[31] || pos >= w) r.err = wtx_pkg::ERR_SHIFT;
          else begin
            // A position of 32 or more leaves the source unchanged.
            if (pos[31:5] != '0) res = a;
            else if (a[pos[4:0]]) res = a | (32'hffffffff << pos[4:0]);
            else res = a & ~(32'hffffffff << pos[4:0]);
            r.err = commit(rd, res, w);
            r.words = 5;
          end
        end
        wtx_pkg::OP_SHL, wtx_pkg::OP_SAR: begin
          if (w > regw[ra]) r.err = wtx_pkg::ERR_BITS;
          else if (b[31] || b >= w) r.err = wtx_pkg::ERR_SHIFT;
          else begin
            if (op == wtx_pkg::OP_SHL) res = (b >= 32) ? 32'd0 : a << b[4:0];
            else if (b >= 32) res = {32{a[31]}};
            else res = sa >>> b[4:0];
            r.err = commit(rd, res, w);
            r.words = 5;
          end
        end
        wtx_pkg::OP_DIV, wtx_pkg::OP_MOD: begin
          if (w > regw[ra] || w > regw[rb]) r.err = wtx_pkg::ERR_BITS;
          else if (b == 0) r.err = wtx_pkg::ERR_DIV0;
          else begin
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            if (op == wtx_pkg::OP_DIV) begin
              res = ua / ub;
              if (a[31] ^ b[31]) res = -res;
            end else begin
              res = ua % ub;
              if (a[31]) res = -res;
            end
            r.err = commit(rd, res, w);
            r.words = 5;
          end
        end
        wtx_pkg::OP_CEQ, wtx_pkg::OP_CNE, wtx_pkg::OP_CLT, wtx_pkg::OP_CGE,
        wtx_pkg::OP_CLE, wtx_pkg::OP_CGT, wtx_pkg::OP_CTZ, wtx_pkg::OP_CTNZ: begin
          if (cw > regw[ra] || cw > regw[rb]) r.err = wtx_pkg::ERR_BITS;
          else begin
            case (op)
              wtx_pkg::OP_CEQ: t = a == b;
              wtx_pkg::OP_CNE: t = a != b;
              wtx_pkg::OP_CLT: t = sa < sb;
              wtx_pkg::OP_CGE: t = !(sa < sb);
              wtx_pkg::OP_CLE: t = !(sb < sa);
              wtx_pkg::OP_CGT: t = sb < sa;
              wtx_pkg::OP_CTZ: t = (a & b) == 0;
              default:         t = (a & b) != 0;
            endcase
            regv[rd] = t ? 32'hffffffff : 32'h0;
            regw[rd] = w;
            r.words = 6;
          end
        end
        default: r.handled = 0;
      endcase
      if (r.err != wtx_pkg::ERR_OK) r.words = 0;
      pending.push_back(r);
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t want;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.err !== want.err) begin
        $error("error_code expected %0d got %0d", want.err, got.err);
        errors++;
      end
      if (got.handled !== want.handled) begin
        $error("handled expected %0d got %0d", want.handled, got.handled);
        errors++;
      end
      if (got.words !== want.words) begin
        $error("words_used expected %0d got %0d", want.words, got.words);
        errors++;
      end
      if (got.skip !== want.skip) begin
        $error("skip_next expected %0d got %0d", want.skip, got.skip);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 5000;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  logic [7:0] in_opcode;
  logic [5:0] in_src_a, in_src_b, in_dest, in_width, in_cmp_width;
  logic signed [31:0] in_immediate;
  logic [2:0] out_error_code, out_words_used;
  logic out_handled, out_skip_next;

  exec_scoreboard sb;
  int idle_cycles;
  int stall_mode;

  width_tagged_integer_exec_unit uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request(in_opcode, in_src_a, in_src_b, in_dest, in_width, in_cmp_width,
                        in_immediate);
      if (out_valid && !out_stall)
        sb.check_result('{out_error_code, out_handled, out_words_used, out_skip_next});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver stall pattern; the mode changes between phases of the run.
  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic send(logic [7:0] op, logic [5:0] ra, logic [5:0] rb, logic [5:0] rd,
                      logic [5:0] w, logic [5:0] cw, logic [31:0] imm);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_src_a <= ra;
    in_src_b <= rb;
    in_dest <= rd;
    in_width <= w;
    in_cmp_width <= cw;
    in_immediate <= imm;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Waits until every outstanding request has its result.
  task automatic drain();
    if (sb.pending.size() != 0) begin
      if (in_valid) in_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      3: return $urandom_range(0, 40);
      4: return -$urandom_range(1, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_opcode();
    logic [7:0] ops [22] = '{wtx_pkg::OP_NOP, wtx_pkg::OP_LIMM, wtx_pkg::OP_CND,
                             wtx_pkg::OP_OR, wtx_pkg::OP_XOR, wtx_pkg::OP_AND,
                             wtx_pkg::OP_SBX, wtx_pkg::OP_ADD, wtx_pkg::OP_SUB,
                             wtx_pkg::OP_MUL, wtx_pkg::OP_SHL, wtx_pkg::OP_SAR,
                             wtx_pkg::OP_DIV, wtx_pkg::OP_MOD, wtx_pkg::OP_CEQ,
                             wtx_pkg::OP_CNE, wtx_pkg::OP_CLT, wtx_pkg::OP_CGE,
                             wtx_pkg::OP_CLE, wtx_pkg::OP_CGT, wtx_pkg::OP_CTZ,
                             wtx_pkg::OP_CTNZ};
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return ops[$urandom_range(0, 21)];
  endfunction

  // Registers are mostly drawn from a small pool so that loaded widths get reused.
  function automatic logic [5:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 6'($urandom);
    return 6'($urandom_range(0, 7));
  endfunction

  initial begin
    int burst;
    int phase_n;
    logic [5:0] w;
    logic [5:0] cw;
    sb = new();
    sb.reset_file();
    rst_n = 0;
    in_valid = 0;
    in_opcode = wtx_pkg::OP_NOP;
    in_src_a = 0;
    in_src_b = 0;
    in_dest = 0;
    in_width = 0;
    in_cmp_width = 0;
    in_immediate = 0;
    out_stall = 0;
    stall_mode = 0;
    idle_cycles = 0;
    phase_n = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: extremes, divide corners, shift and sign extend corners, compares, unknown opcodes.
    send(wtx_pkg::OP_NOP, 0, 0, 0, 0, 0, 0);
    send(wtx_pkg::OP_CND, 0, 0, 0, 0, 0, 0);
    send(wtx_pkg::OP_LIMM, 0, 0, 1, 32, 0, 32'h80000000);
    send(wtx_pkg::OP_LIMM, 0, 0, 2, 32, 0, 32'hffffffff);
    send(wtx_pkg::OP_DIV, 1, 2, 3, 32, 0, 0);
    send(wtx_pkg::OP_MOD, 1, 2, 4, 32, 0, 0);
    send(wtx_pkg::OP_LIMM, 0, 0, 5, 32, 0, 0);
    send(wtx_pkg::OP_DIV, 1, 5, 6, 32, 0, 0);
    send(wtx_pkg::OP_LIMM, 0, 0, 7, 63, 0, 40);
    send(wtx_pkg::OP_SHL, 2, 7, 8, 32, 0, 0);
    send(wtx_pkg::OP_SAR, 1, 7, 8, 32, 0, 0);
    send(wtx_pkg::OP_LIMM, 0, 0, 63, 32, 0, 31);
    send(wtx_pkg::OP_SBX, 1, 0, 9, 32, 0, 0);
    send(wtx_pkg::OP_LIMM, 0, 0, 63, 32, 0, 32'hffffffff);
    send(wtx_pkg::OP_SBX, 1, 0, 9, 32, 0, 0);
    send(wtx_pkg::OP_LIMM, 0, 0, 10, 8, 0, 200);
    send(wtx_pkg::OP_LIMM, 0, 0, 11, 1, 0, 32'hffffffff);
    send(wtx_pkg::OP_ADD, 10, 11, 12, 9, 0, 0);
    send(wtx_pkg::OP_CLT, 1, 2, 13, 63, 32, 0);
    send(wtx_pkg::OP_CGE, 1, 2, 13, 5, 33, 0);
    send(wtx_pkg::OP_CND, 2, 0, 0, 0, 0, 0);
    send(wtx_pkg::OP_MUL, 1, 2, 14, 0, 0, 0);
    send(8'h17, 63, 63, 63, 63, 63, 32'h7fffffff);
    send(8'hff, 0, 0, 0, 0, 0, 0);
    drain();

    for (int n = 0; n < 650; ) begin
      if (n >= phase_n) begin
        drain();
        stall_mode = $urandom_range(0, 2);
        phase_n += 150;
      end
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++, n++) begin
        w = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32));
        cw = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32));
        if ($urandom_range(0, 3) == 0)
          send(wtx_pkg::OP_LIMM, 0, 0, pick_reg(), ($urandom_range(0, 1) ? 6'd32 : w), 0,
               pick_value());
        else if ($urandom_range(0, 15) == 0)
          send(wtx_pkg::OP_LIMM, 0, 0, wtx_pkg::SHIFT_REG, 32, 0, $urandom_range(0, 34));
        else
          send(pick_opcode(), pick_reg(), pick_reg(), pick_reg(), w, cw, pick_value());
      end
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 20));
    end
    drain();
    repeat (60) @(negedge clk);
    $display("Ran %0d instructions over all opcodes with mixed widths and stalls.",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* filelist.f */
rtl/wtx_pkg.sv
rtl/wtx_datapath.sv
rtl/wtx_ctrl.sv
rtl/width_tagged_integer_exec_unit.sv
bench/width_tagged_integer_exec_unit_tb.sv
